/* rtl/ibp_pkg.sv */
`default_nettype none

package ibp_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 6;
    localparam int RES_SLOTS  = 3;   // worst case: two full bytes plus a padded tail
    localparam int SLOT_W     = 2;

    // parameter defaults
    localparam int DEF_SAMPLES_PER_BLOCK = 24;
    localparam int DEF_MAX_WIDTH         = 16;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd9;

    // bytes produced by one sample, handed from the packer to the output stage
    typedef struct packed {
        logic [RES_SLOTS-1:0][BYTE_W-1:0] bytes;  // slot 0 goes out first
        logic [SLOT_W-1:0]                cnt;    // number of valid slots
        logic                             last;   // last slot closes the block
        logic [CNT_W-1:0]                 blk;    // byte count of the block
    } t_res;

endpackage

`default_nettype wire

/* rtl/ibp_core.sv */
`default_nettype none

// Bit accumulator: merges one sample into the partial byte and splits
// the result into up to three bytes. Block state advances on i_load.
module ibp_core #(
    parameter int SAMPLES_PER_BLOCK = ibp_pkg::DEF_SAMPLES_PER_BLOCK,
    parameter int MAX_WIDTH         = ibp_pkg::DEF_MAX_WIDTH
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_load,
    input  wire  [ibp_pkg::SAMPLE_W-1:0]     i_sample,
    input  wire  [ibp_pkg::CFG_W-1:0]        i_width,
    output ibp_pkg::t_res                    o_res
);
    import ibp_pkg::*;

    localparam int AW    = 7 + MAX_WIDTH;               // accumulator width
    localparam int TW    = $clog2(AW + 1);               // bit total width
    localparam int IDX_W = $clog2(SAMPLES_PER_BLOCK + 1);
    localparam logic [IDX_W-1:0] IDX_END = IDX_W'(SAMPLES_PER_BLOCK - 1);

    logic [6:0]        r_pend;
    logic [2:0]        r_pcnt;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_emit;

    logic [6:0]        n_pend;
    logic [2:0]        n_pcnt;
    logic [IDX_W-1:0]  n_idx;
    logic [CNT_W-1:0]  n_emit;

    logic [CFG_W-1:0]  w_eff;
    logic [AW-1:0]     v_mask;
    logic [AW-1:0]     acc;
    logic [TW-1:0]     total;
    logic [1:0]        nfull;
    logic [2:0]        rem_n;
    logic [7:0]        rem_mask;
    logic [7:0]        rem_bits;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [7:0]        pad;
    logic              blk_end;
    logic              pad_en;
    logic [SLOT_W-1:0] n_out;
    logic [CNT_W-1:0]  emit_sum;

    // clamp the width register to 1..MAX_WIDTH
    always_comb begin
        if (i_width == '0) begin
            w_eff = CFG_W'(1);
        end else if (i_width > CFG_W'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
    end

    // merge sample bits behind the pending ones
    assign v_mask = (AW'(1) << w_eff) - AW'(1);
    assign acc    = (AW'(r_pend) << w_eff) | (AW'(i_sample) & v_mask);
    assign total  = TW'(r_pcnt) + TW'(w_eff);
    assign nfull  = 2'(total >> 3);
    assign rem_n  = total[2:0];

    // full bytes, earliest bits first
    assign byte0 = 8'(acc >> (total - TW'(8)));
    assign byte1 = 8'(acc >> (total - TW'(16)));

    // leftover bits, left aligned and zero padded for a block end
    assign rem_mask = (8'd1 << rem_n) - 8'd1;
    assign rem_bits = 8'(acc) & rem_mask;
    assign pad      = rem_bits << (4'd8 - {1'b0, rem_n});

    assign blk_end  = (r_idx == IDX_END);
    assign pad_en   = blk_end && (rem_n != 3'd0);
    assign n_out    = nfull + SLOT_W'(pad_en);
    assign emit_sum = r_emit + CNT_W'(n_out);

    // result bundle
    always_comb begin
        o_res.bytes[0] = (nfull != 2'd0) ? byte0 : pad;
        o_res.bytes[1] = (nfull == 2'd2) ? byte1 : pad;
        o_res.bytes[2] = pad;
        o_res.cnt      = n_out;
        o_res.last     = blk_end;
        o_res.blk      = emit_sum;
    end

    // next block state
    always_comb begin
        if (blk_end) begin
            n_pend = '0;
            n_pcnt = '0;
            n_idx  = '0;
            n_emit = '0;
        end else begin
            n_pend = rem_bits[6:0];
            n_pcnt = rem_n;
            n_idx  = r_idx + IDX_W'(1);
            n_emit = emit_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_pcnt <= '0;
            r_idx  <= '0;
            r_emit <= '0;
        end else if (i_load) begin
            r_pend <= n_pend;
            r_pcnt <= n_pcnt;
            r_idx  <= n_idx;
            r_emit <= n_emit;
        end
    end

endmodule

`default_nettype wire

/* rtl/ibp_out.sv */
`default_nettype none

// Result register: holds one sample's bytes and sends them one per cycle while i_ready is high.
module ibp_out (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_load,
    input  ibp_pkg::t_res                 i_res,
    output logic                          o_free,
    input  wire                           i_ready,
    output logic                          o_valid,
    output logic [ibp_pkg::BYTE_W-1:0]    o_byte,
    output logic                          o_last,
    output logic [ibp_pkg::CNT_W-1:0]     o_blk
);
    import ibp_pkg::*;

    logic [RES_SLOTS-1:0][BYTE_W-1:0] r_bytes;
    logic [SLOT_W-1:0]                r_cnt;
    logic                             r_last;
    logic [CNT_W-1:0]                 r_blk;
    logic                             fire;

    assign o_valid = (r_cnt != '0);
    assign fire    = o_valid && i_ready;
    // free when empty or when the final byte leaves now
    assign o_free  = (r_cnt == '0) || ((r_cnt == SLOT_W'(1)) && i_ready);

    assign o_byte  = r_bytes[0];
    assign o_last  = r_last && (r_cnt == SLOT_W'(1));
    assign o_blk   = o_last ? r_blk : '0;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_res.cnt;
        end else if (fire) begin
            r_cnt <= r_cnt - SLOT_W'(1);
        end
    end

    // payload: load or shift toward slot 0
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes <= i_res.bytes;
            r_last  <= i_res.last;
            r_blk   <= i_res.blk;
        end else if (fire) begin
            r_bytes[0] <= r_bytes[1];
            r_bytes[1] <= r_bytes[2];
        end
    end

endmodule

`default_nettype wire

/* rtl/iq_sample_bit_packer.sv */
// Packs the low sample_width bits (1..16, values 0 and above 16 clamp) of
// each 16-bit sample into bytes, most significant bit first. Each block of
// SAMPLES_PER_BLOCK samples ends byte aligned; a partial tail is zero padded,
// and its final byte carries tlast with the block byte count in tdata[13:8].
// A sample waits in the input register until the result register is free,
// is packed into the result register, and its 0 to 3 bytes go out one per
// cycle while m_axis_tready is high; the next sample is taken while the last
// byte of the previous one is handed over. Width writes take effect from the
// next sample packed and should be made while the block is idle.
`default_nettype none

module iq_sample_bit_packer #(
    parameter int SAMPLES_PER_BLOCK = ibp_pkg::DEF_SAMPLES_PER_BLOCK,
    parameter int MAX_WIDTH         = ibp_pkg::DEF_MAX_WIDTH
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // width register write
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [ibp_pkg::CFG_W-1:0]    i_cfg_data,    // sample_width
    // sample input
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [15:0]                  s_axis_tdata,  // [15:0] sample_value
    // byte output
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [15:0]                  m_axis_tdata,  // [7:0] packed_byte,
                                                        // [13:8] block_bytes
    output logic                         m_axis_tlast   // last_byte
);
    import ibp_pkg::*;

    logic [CFG_W-1:0]    r_width;
    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                free;
    logic                load;
    t_res                res;
    logic [BYTE_W-1:0]   out_byte;
    logic [CNT_W-1:0]    out_blk;

    // width register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_width <= i_cfg_data;
        end
    end

    // input register
    assign load          = r_in_valid && free;
    assign s_axis_tready = !r_in_valid || load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_sample <= s_axis_tdata;
        end
    end

    ibp_core #(
        .SAMPLES_PER_BLOCK (SAMPLES_PER_BLOCK),
        .MAX_WIDTH         (MAX_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_sample (r_sample),
        .i_width  (r_width),
        .o_res    (res)
    );

    ibp_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_res    (res),
        .o_free   (free),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_byte   (out_byte),
        .o_last   (m_axis_tlast),
        .o_blk    (out_blk)
    );

    assign m_axis_tdata = {2'b00, out_blk, out_byte};

endmodule

`default_nettype wire

/* rtl/ibp_checker.sv */
`default_nettype none

// Port-level checks for the bit packer.
module ibp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    logic [5:0] r_seen;
    logic       out_fire;

    assign out_fire = m_axis_tvalid && m_axis_tready;

    // bytes sent so far in the current block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (out_fire) begin
            r_seen <= m_axis_tlast ? 6'd0 : r_seen + 6'd1;
        end
    end

    // block count matches the bytes actually sent
    a_blk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && m_axis_tlast |-> m_axis_tdata[13:8] == r_seen + 6'd1)
        else $error("block byte count does not match bytes sent");

    // count field only on the closing byte
    a_blk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[13:8] == 6'd0)
        else $error("block byte count set on a non-final byte");

    // padding bits of tdata stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:14] == 2'b00)
        else $error("tdata pad bits set");

    // stalled transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

endmodule

bind iq_sample_bit_packer ibp_checker u_ibp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* sim/iq_sample_bit_packer_test.sv */
`default_nettype none

module iq_sample_bit_packer_test;
    import ibp_pkg::*;

    localparam int BLOCK_SAMPLES = DEF_SAMPLES_PER_BLOCK;
    localparam int WIDTH_CAP     = DEF_MAX_WIDTH;
    localparam int SETTLE_CYCLES = 8;     // pipeline depth plus margin
    localparam int HOLD_CYCLES   = 300;   // long receiver stall
    localparam int RANDOM_ITEMS  = 156;   // on top of the 24 directed samples

    // one expected output byte transaction
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [CNT_W-1:0]  count;
    } t_packed_byte;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [CFG_W-1:0]  i_cfg_data    = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;    // [15:0] sample_value
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;          // [7:0] packed_byte, [13:8] block_bytes
    logic              m_axis_tlast;          // last_byte

    iq_sample_bit_packer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // packer state as predicted
    logic [CFG_W-1:0] width_reg   = CFG_RESET;
    logic [6:0]       pend_bits   = '0;
    logic [2:0]       pend_cnt    = '0;
    int unsigned      blk_samples = 0;
    logic [CNT_W-1:0] blk_bytes   = '0;

    t_packed_byte        expected_bytes[$];
    logic [SAMPLE_W-1:0] sample_q[$];
    logic [CFG_W-1:0]    width_q[$];

    int  samples_queued = 0;
    int  samples_taken  = 0;
    int  widths_queued  = 0;
    int  widths_written = 0;
    int  bytes_seen     = 0;
    int  blocks_seen    = 0;
    int  err_cnt        = 0;
    int  src_gap        = 0;
    int  rx_gap         = 0;
    bit  idle_en        = 1'b1;
    bit  hold_go        = 1'b0;
    logic rx_hold       = 1'b0;

    function automatic void report_error(string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // pack one sample, queue the bytes it completes
    function automatic void pack_sample(logic [SAMPLE_W-1:0] smp);
        int unsigned  w;
        int unsigned  acc;
        int unsigned  total;
        int unsigned  n;
        t_packed_byte res[RES_SLOTS];
        w = width_reg;
        if (w == 0) w = 1;
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        acc   = (32'(pend_bits) << w) | (32'(smp) & ((32'd1 << w) - 1));
        total = 32'(pend_cnt) + w;
        n     = 0;
        while (total >= 8) begin
            res[n] = '{8'(acc >> (total - 8)), 1'b0, '0};
            n++;
            total -= 8;
            acc &= (32'd1 << total) - 1;
            blk_bytes++;
        end
        blk_samples++;
        if (blk_samples >= BLOCK_SAMPLES) begin
            // tail of the block: zero pad, then mark the final byte
            if (total > 0) begin
                res[n] = '{8'(acc << (8 - total)), 1'b0, '0};
                n++;
                blk_bytes++;
            end
            res[n-1].last  = 1'b1;
            res[n-1].count = blk_bytes;
            pend_bits   = '0;
            pend_cnt    = '0;
            blk_samples = 0;
            blk_bytes   = '0;
        end else begin
            pend_bits = 7'(acc);
            pend_cnt  = 3'(total);
        end
        for (int k = 0; k < n; k++)
            expected_bytes.push_back(res[k]);
    endfunction

    // width register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                width_reg = i_cfg_data;
                widths_written++;
            end
            if (!i_cfg_valid || o_cfg_ready) begin
                if (width_q.size() != 0) begin
                    i_cfg_valid <= 1'b1;
                    i_cfg_data  <= width_q.pop_front();
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
        end
    end

    // sample sender, predicts on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pack_sample(s_axis_tdata);
                samples_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= sample_q.pop_front();
                    if (idle_en && $urandom_range(0, 5) == 0)
                        src_gap = $urandom_range(1, 18);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // byte receiver and checker
    always @(posedge i_clk) begin : byte_monitor
        t_packed_byte want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                bytes_seen++;
                if (m_axis_tlast) blocks_seen++;
                if (expected_bytes.size() == 0) begin
                    report_error($sformatf("unexpected byte %h last %b count %0d",
                        m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[13:8]));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_axis_tdata[7:0] !== want.data || m_axis_tlast !== want.last ||
                        m_axis_tdata[13:8] !== want.count)
                        report_error($sformatf(
                            "byte %0d: want %h last %b count %0d, got %h last %b count %0d",
                            bytes_seen, want.data, want.last, want.count,
                            m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[13:8]));
                end
            end
            if (rx_hold) begin
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (idle_en && $urandom_range(0, 6) == 0)
                    rx_gap = $urandom_range(1, 18);
            end
        end
    end

    // one long receiver stall, so the packer backs up into its input
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timed out with %0d bytes still expected", expected_bytes.size());
        $display("[iq_sample_bit_packer] ERROR");
        $finish;
    end

    task automatic write_width(logic [CFG_W-1:0] w);
        width_q.push_back(w);
        widths_queued++;
        while (widths_written != widths_queued) @(posedge i_clk);
    endtask

    task automatic send_samples(logic [SAMPLE_W-1:0] vals[$]);
        foreach (vals[k]) sample_q.push_back(vals[k]);
        samples_queued += vals.size();
    endtask

    // all samples taken, all bytes back, then let the pipeline settle
    task automatic wait_idle();
        @(posedge i_clk);
        while (samples_taken != samples_queued || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : sequencer
        logic [SAMPLE_W-1:0] vals[$];
        logic [SAMPLE_W-1:0] v;
        int                  rand_sent;
        int                  len;
        int                  w;
        bit                  pressure_done;
        rand_sent     = 0;
        pressure_done = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: one full block across widths 9 (reset), 0, 31, 16 and 1
        send_samples('{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA});
        wait_idle();
        write_width(5'd0);
        send_samples('{16'h0001, 16'h0000, 16'hFFFE, 16'hFFFF});
        wait_idle();
        write_width(5'd31);
        send_samples('{16'hFFFF, 16'h8000, 16'h1234, 16'h0000});
        wait_idle();
        write_width(5'd16);
        send_samples('{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'hA5C3, 16'h5A3C});
        wait_idle();
        write_width(5'd1);
        send_samples('{16'h0001, 16'h0000, 16'h0001, 16'hFFFF});
        wait_idle();

        // random phases, each with its own width; the last one runs without idling
        while (rand_sent < RANDOM_ITEMS) begin
            len = $urandom_range(10, 36);
            case ($urandom_range(0, 7))
                0:       w = 0;
                1:       w = $urandom_range(17, 31);
                default: w = $urandom_range(1, 16);
            endcase
            idle_en = ($urandom_range(0, 3) != 0);
            if (!pressure_done && rand_sent >= 60) begin
                w             = WIDTH_CAP;
                len           = 40;
                idle_en       = 1'b0;
                hold_go       = 1'b1;
                pressure_done = 1'b1;
            end
            if (rand_sent + len >= RANDOM_ITEMS) begin
                len     = RANDOM_ITEMS - rand_sent;
                idle_en = 1'b0;
            end
            write_width(5'(w));
            vals.delete();
            for (int k = 0; k < len; k++) begin
                v = 16'($urandom);
                if ($urandom_range(0, 7) == 0)
                    v = v[0] ? 16'hFFFF : (v[1] ? 16'h8000 : 16'h0000);
                vals.push_back(v);
            end
            send_samples(vals);
            rand_sent += len;
            wait_idle();
        end

        $display("run covered %0d samples over %0d width writes, %0d bytes in %0d blocks",
                 samples_taken, widths_written, bytes_seen, blocks_seen);
        $display("mismatches found: %0d", err_cnt);
        if (err_cnt == 0)
            $display("[iq_sample_bit_packer] OK");
        else
            $display("[iq_sample_bit_packer] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/ibp_pkg.sv
rtl/ibp_core.sv
rtl/ibp_out.sv
rtl/iq_sample_bit_packer.sv
rtl/ibp_checker.sv
sim/iq_sample_bit_packer_test.sv
